[rtl/ftrr_pkg.sv]
`timescale 1ns / 1ps

package ftrr_pkg;

	localparam int unsigned RecordBytes = 36;
	localparam int unsigned RecordWords = RecordBytes / 4;
	localparam int unsigned ByteIdxW    = $clog2(RecordBytes + 1);
	localparam int unsigned WordIdxW    = $clog2(RecordWords);
	localparam int unsigned Axes        = 6;
	localparam int unsigned ScaledW     = 48;
	localparam int unsigned ProdShift   = 16;
	localparam int unsigned DescDepth   = 4;
	localparam int unsigned DescPtrW    = $clog2(DescDepth);
	localparam int unsigned DescCntW    = $clog2(DescDepth + 1);
	localparam int unsigned ResDepth    = 8;
	localparam int unsigned ResPtrW     = $clog2(ResDepth);
	localparam int unsigned ResCntW     = $clog2(ResDepth + 1);
	localparam int unsigned CfgIdxW     = 2;

	localparam logic [31:0] ScaleReset = 32'd4295;

	localparam logic [CfgIdxW-1:0] CfgForceScale  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CfgTorqueScale = CfgIdxW'(1);

	typedef enum logic [1:0] {
		OUTCOME_GOOD       = 2'd0,
		OUTCOME_WRONG_SIZE = 2'd1,
		OUTCOME_STALE      = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_datagram;
	} item_t;

	typedef struct packed {
		outcome_t                   outcome;
		logic signed [ScaledW-1:0]  force_x;
		logic signed [ScaledW-1:0]  force_y;
		logic signed [ScaledW-1:0]  force_z;
		logic signed [ScaledW-1:0]  torque_x;
		logic signed [ScaledW-1:0]  torque_y;
		logic signed [ScaledW-1:0]  torque_z;
		logic [31:0]                device_status;
		logic [31:0]                good_count;
		logic [31:0]                lost_count;
		logic [31:0]                stale_count;
	} result_t;

	typedef struct packed {
		logic                   wrong_size;
		logic [31:0]            rec_seq;
		logic [31:0]            status;
		logic [Axes-1:0][31:0]  counts;
	} desc_t;

	typedef struct packed {
		logic               valid;
		logic [CfgIdxW-1:0] index;
		logic [31:0]        data;
	} cfg_req_t;

endpackage

[rtl/force_torque_record_receiver_top.sv]
`timescale 1ns / 1ps
// Descriptors pass the descriptor queue, two scaling stages and the result queue.
// Throughput: one byte per cycle; one result per cycle while the result queue has room.
// Bytes are taken while the four-entry descriptor queue between parser and scaler has room.
// Reset: counters, last sequence and status latch clear, both scales return to 4295;
// the record word store is not cleared and no clearing pass is needed.

module force_torque_record_receiver_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  ftrr_pkg::item_t                    item,
	output logic                               empty,
	input  logic                               pop,
	output ftrr_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ftrr_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [31:0]                        cfg_data
);

	logic               take;
	logic               desc_valid;
	ftrr_pkg::desc_t    desc_in;
	ftrr_pkg::desc_t    desc_out;
	logic               desc_empty;
	logic               desc_pop;
	ftrr_pkg::cfg_req_t cfg;

	assign take      = push & ~full;
	assign cfg_ready = 1'b1;

	always_comb begin
		cfg.valid = cfg_valid & cfg_ready;
		cfg.index = cfg_index;
		cfg.data  = cfg_data;
	end

	ftrr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (item),
		.desc_valid (desc_valid),
		.desc       (desc_in)
	);

	ftrr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (desc_valid),
		.wr_data (desc_in),
		.full    (full),
		.rd_en   (desc_pop),
		.rd_data (desc_out),
		.empty   (desc_empty)
	);

	ftrr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.desc_empty (desc_empty),
		.desc       (desc_out),
		.desc_pop   (desc_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

[rtl/ftrr_front.sv]
`timescale 1ns / 1ps

module ftrr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  ftrr_pkg::item_t   item,
	output logic              desc_valid,
	output ftrr_pkg::desc_t   desc
);

	logic [ftrr_pkg::ByteIdxW-1:0]                  byte_idx_q;
	logic [ftrr_pkg::RecordWords-1:0][31:0]         words_q;
	logic [ftrr_pkg::RecordWords-1:0][31:0]         merged;
	logic [ftrr_pkg::WordIdxW-1:0]                  word_sel;
	logic [1:0]                                     lane;
	logic                                           in_record;

	always_comb begin
		merged    = words_q;
		word_sel  = byte_idx_q[ftrr_pkg::WordIdxW+1:2];
		lane      = byte_idx_q[1:0];
		in_record = byte_idx_q < ftrr_pkg::ByteIdxW'(ftrr_pkg::RecordBytes);
		if (in_record) begin
			merged[word_sel][{~lane, 3'b000} +: 8] = item.data_byte;
		end
	end

	always_comb begin
		desc.wrong_size = byte_idx_q != ftrr_pkg::ByteIdxW'(ftrr_pkg::RecordBytes - 1);
		desc.rec_seq    = merged[0];
		desc.status     = merged[2];
		for (int k = 0; k < ftrr_pkg::Axes; k++) begin
			desc.counts[k] = merged[3 + k];
		end
	end

	assign desc_valid = take & item.end_of_datagram;

	always_ff @(posedge clk) begin
		if (take) begin
			words_q <= merged;
		end
	end

	// saturate past the record so a long datagram ends as wrong size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
		end else if (take) begin
			if (item.end_of_datagram) begin
				byte_idx_q <= '0;
			end else if (in_record) begin
				byte_idx_q <= byte_idx_q + 1'b1;
			end
		end
	end

endmodule

[rtl/ftrr_queue.sv]
`timescale 1ns / 1ps

module ftrr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  ftrr_pkg::desc_t  wr_data,
	output logic             full,
	input  logic             rd_en,
	output ftrr_pkg::desc_t  rd_data,
	output logic             empty
);

	ftrr_pkg::desc_t                 mem_q [ftrr_pkg::DescDepth];
	logic [ftrr_pkg::DescPtrW-1:0]   wr_ptr_q;
	logic [ftrr_pkg::DescPtrW-1:0]   rd_ptr_q;
	logic [ftrr_pkg::DescCntW-1:0]   count_q;

	assign full    = count_q == ftrr_pkg::DescCntW'(ftrr_pkg::DescDepth);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + ftrr_pkg::DescCntW'(wr_en) - ftrr_pkg::DescCntW'(rd_en);
		end
	end

endmodule

[rtl/ftrr_back.sv]
`timescale 1ns / 1ps

module ftrr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ftrr_pkg::cfg_req_t  cfg,
	input  logic                desc_empty,
	input  ftrr_pkg::desc_t     desc,
	output logic                desc_pop,
	output logic                empty,
	input  logic                pop,
	output ftrr_pkg::result_t   result
);

	typedef struct packed {
		ftrr_pkg::outcome_t          outcome;
		logic [31:0]                 status;
		logic [31:0]                 good;
		logic [31:0]                 lost;
		logic [31:0]                 stale;
		logic [ftrr_pkg::Axes-1:0]   neg;
	} meta_t;

	logic [31:0] force_scale_q;
	logic [31:0] torque_scale_q;
	logic [31:0] last_seq_q;
	logic [31:0] status_q;
	logic [31:0] good_q;
	logic [31:0] lost_q;
	logic [31:0] stale_q;

	logic [31:0]        diff;
	logic               stale;
	meta_t              meta_nxt;
	logic [31:0]        seq_nxt;
	logic [ftrr_pkg::Axes-1:0][31:0] mag_nxt;

	logic                             v_s1;
	meta_t                            meta_s1;
	logic [ftrr_pkg::Axes-1:0][31:0]  mag_s1;
	logic                             v_s2;
	meta_t                            meta_s2;
	logic [ftrr_pkg::Axes-1:0][63:0]  prod_s2;

	logic [ftrr_pkg::Axes-1:0][ftrr_pkg::ScaledW-1:0] scaled;
	ftrr_pkg::result_t                res_in;

	ftrr_pkg::result_t                res_mem_q [ftrr_pkg::ResDepth];
	logic [ftrr_pkg::ResPtrW-1:0]     res_wr_q;
	logic [ftrr_pkg::ResPtrW-1:0]     res_rd_q;
	logic [ftrr_pkg::ResCntW-1:0]     res_cnt_q;
	logic [ftrr_pkg::ResCntW-1:0]     committed;
	logic                             res_pop;

	// issue only when every request in flight has a slot waiting
	assign committed = res_cnt_q + ftrr_pkg::ResCntW'(v_s1) + ftrr_pkg::ResCntW'(v_s2);
	assign desc_pop  = !desc_empty && (committed < ftrr_pkg::ResCntW'(ftrr_pkg::ResDepth));

	always_comb begin
		diff           = desc.rec_seq - last_seq_q;
		stale          = (diff == '0) || diff[31];
		seq_nxt        = last_seq_q;
		meta_nxt.status = status_q;
		meta_nxt.good  = good_q;
		meta_nxt.lost  = lost_q;
		meta_nxt.stale = stale_q;
		meta_nxt.outcome = ftrr_pkg::OUTCOME_WRONG_SIZE;
		if (!desc.wrong_size) begin
			seq_nxt = desc.rec_seq;
			if (desc.status != '0) begin
				meta_nxt.status = desc.status;
			end
			if (stale) begin
				meta_nxt.stale   = stale_q + 32'd1;
				meta_nxt.outcome = ftrr_pkg::OUTCOME_STALE;
			end else begin
				meta_nxt.lost    = lost_q + diff - 32'd1;
				meta_nxt.good    = good_q + 32'd1;
				meta_nxt.outcome = ftrr_pkg::OUTCOME_GOOD;
			end
		end
		for (int k = 0; k < ftrr_pkg::Axes; k++) begin
			meta_nxt.neg[k] = desc.counts[k][31];
			mag_nxt[k]      = desc.counts[k][31] ? (~desc.counts[k] + 32'd1) : desc.counts[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_scale_q  <= ftrr_pkg::ScaleReset;
			torque_scale_q <= ftrr_pkg::ScaleReset;
			last_seq_q     <= '0;
			status_q       <= '0;
			good_q         <= '0;
			lost_q         <= '0;
			stale_q        <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
		end else begin
			if (cfg.valid && cfg.index == ftrr_pkg::CfgForceScale) begin
				force_scale_q <= cfg.data;
			end
			if (cfg.valid && cfg.index == ftrr_pkg::CfgTorqueScale) begin
				torque_scale_q <= cfg.data;
			end
			if (desc_pop) begin
				last_seq_q <= seq_nxt;
				status_q   <= meta_nxt.status;
				good_q     <= meta_nxt.good;
				lost_q     <= meta_nxt.lost;
				stale_q    <= meta_nxt.stale;
			end
			v_s1 <= desc_pop;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_pop) begin
			meta_s1 <= meta_nxt;
			mag_s1  <= mag_nxt;
		end
		if (v_s1) begin
			meta_s2 <= meta_s1;
			for (int k = 0; k < ftrr_pkg::Axes; k++) begin
				prod_s2[k] <= 64'(mag_s1[k])
					* 64'((k < ftrr_pkg::Axes / 2) ? force_scale_q : torque_scale_q);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < ftrr_pkg::Axes; k++) begin
			scaled[k] = prod_s2[k][ftrr_pkg::ProdShift +: ftrr_pkg::ScaledW];
			if (meta_s2.neg[k]) begin
				scaled[k] = ~scaled[k] + ftrr_pkg::ScaledW'(1);
			end
			if (meta_s2.outcome != ftrr_pkg::OUTCOME_GOOD) begin
				scaled[k] = '0;
			end
		end
		res_in.outcome       = meta_s2.outcome;
		res_in.force_x       = scaled[0];
		res_in.force_y       = scaled[1];
		res_in.force_z       = scaled[2];
		res_in.torque_x      = scaled[3];
		res_in.torque_y      = scaled[4];
		res_in.torque_z      = scaled[5];
		res_in.device_status = meta_s2.status;
		res_in.good_count    = meta_s2.good;
		res_in.lost_count    = meta_s2.lost;
		res_in.stale_count   = meta_s2.stale;
	end

	assign empty   = res_cnt_q == '0;
	assign res_pop = pop & !empty;
	assign result  = res_mem_q[res_rd_q];

	always_ff @(posedge clk) begin
		if (v_s2) begin
			res_mem_q[res_wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (v_s2) begin
				res_wr_q <= res_wr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			res_cnt_q <= res_cnt_q + ftrr_pkg::ResCntW'(v_s2) - ftrr_pkg::ResCntW'(res_pop);
		end
	end

endmodule

[rtl/ftrr_checker.sv]
`timescale 1ns / 1ps

module ftrr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input ftrr_pkg::result_t  result
);

	logic [31:0] prev_good_q;
	logic [31:0] prev_stale_q;
	logic [31:0] prev_status_q;
	logic        taken;
	logic        is_good;
	logic        is_stale;

	assign taken    = pop & !empty;
	assign is_good  = result.outcome == ftrr_pkg::OUTCOME_GOOD;
	assign is_stale = result.outcome == ftrr_pkg::OUTCOME_STALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_good_q   <= '0;
			prev_stale_q  <= '0;
			prev_status_q <= '0;
		end else if (taken) begin
			prev_good_q   <= result.good_count;
			prev_stale_q  <= result.stale_count;
			prev_status_q <= result.device_status;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_good) |-> (result.force_x == '0 && result.force_y == '0 &&
			result.force_z == '0 && result.torque_x == '0 &&
			result.torque_y == '0 && result.torque_z == '0))
		else $error("scaled values nonzero on rejected record");

	assert property (@(posedge clk) disable iff (!arst_n)
		taken |-> (result.good_count == prev_good_q + {31'd0, is_good}))
		else $error("good count step mismatch");

	assert property (@(posedge clk) disable iff (!arst_n)
		taken |-> (result.stale_count == prev_stale_q + {31'd0, is_stale}))
		else $error("stale count step mismatch");

	assert property (@(posedge clk) disable iff (!arst_n)
		(taken && result.outcome == ftrr_pkg::OUTCOME_WRONG_SIZE)
			|-> (result.device_status == prev_status_q))
		else $error("status changed on wrong-size datagram");

endmodule

bind force_torque_record_receiver_top ftrr_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam logic [ftrr_pkg::CfgIdxW-1:0] CfgSpareA = ftrr_pkg::CfgIdxW'(2);
	localparam logic [ftrr_pkg::CfgIdxW-1:0] CfgSpareB = ftrr_pkg::CfgIdxW'(3);

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           push = 1'b0;
	logic                           full;
	ftrr_pkg::item_t                item = '0;
	logic                           empty;
	logic                           pop = 1'b0;
	ftrr_pkg::result_t              result;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ftrr_pkg::CfgIdxW-1:0]   cfg_index = '0;
	logic [31:0]                    cfg_data = '0;

	force_torque_record_receiver_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ftrr_pkg::item_t   pending_bytes [$];
	ftrr_pkg::result_t expected_reports [$];
	int unsigned       mismatches = 0;

	int unsigned tx_gap_max = 2;
	int unsigned rx_gap_max = 2;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_hold = 0;
	bit          rx_stall_req = 1'b0;
	bit          rx_stall_done = 1'b0;
	logic [31:0] gen_seq = '0;

	// parser and counter state as the block should hold it
	int unsigned rx_pos = 0;
	logic [31:0] rx_words [ftrr_pkg::RecordWords];
	logic [31:0] prev_seq = '0;
	logic [31:0] status_hold = '0;
	logic [31:0] n_good = '0;
	logic [31:0] n_lost = '0;
	logic [31:0] n_stale = '0;
	logic [31:0] f_scale = ftrr_pkg::ScaleReset;
	logic [31:0] t_scale = ftrr_pkg::ScaleReset;

	function automatic logic signed [ftrr_pkg::ScaledW-1:0] scale_count(logic [31:0] cnt,
			logic [31:0] k);
		logic [32:0]                  mag;
		logic [64:0]                  prod;
		logic [ftrr_pkg::ScaledW-1:0] q;
		mag = cnt[31] ? (33'h1_0000_0000 - {1'b0, cnt}) : {1'b0, cnt};
		prod = mag * k;
		q = prod[ftrr_pkg::ProdShift +: ftrr_pkg::ScaledW];
		return cnt[31] ? -q : q;
	endfunction

	function automatic void parse_byte(ftrr_pkg::item_t it);
		ftrr_pkg::result_t r;
		logic [31:0]       seq;
		logic [31:0]       diff;
		int unsigned       at;
		at = rx_pos;
		if (at < ftrr_pkg::RecordBytes) begin
			rx_words[at >> 2][(3 - (at & 3)) * 8 +: 8] = it.data_byte;
			rx_pos = at + 1;
		end
		if (!it.end_of_datagram)
			return;
		rx_pos = 0;
		r = '0;
		if (at != ftrr_pkg::RecordBytes - 1) begin
			r.outcome = ftrr_pkg::OUTCOME_WRONG_SIZE;
		end else begin
			seq = rx_words[0];
			diff = seq - prev_seq;
			if (rx_words[2] != 0)
				status_hold = rx_words[2];
			prev_seq = seq;
			if (diff == 0 || diff[31]) begin
				n_stale = n_stale + 1;
				r.outcome = ftrr_pkg::OUTCOME_STALE;
			end else begin
				n_lost = n_lost + diff - 1;
				n_good = n_good + 1;
				r.outcome = ftrr_pkg::OUTCOME_GOOD;
				r.force_x = scale_count(rx_words[3], f_scale);
				r.force_y = scale_count(rx_words[4], f_scale);
				r.force_z = scale_count(rx_words[5], f_scale);
				r.torque_x = scale_count(rx_words[6], t_scale);
				r.torque_y = scale_count(rx_words[7], t_scale);
				r.torque_z = scale_count(rx_words[8], t_scale);
			end
		end
		r.device_status = status_hold;
		r.good_count = n_good;
		r.lost_count = n_lost;
		r.stale_count = n_stale;
		expected_reports.insert(expected_reports.size(), r);
	endfunction

	function automatic void cmp_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_report(ftrr_pkg::result_t got);
		ftrr_pkg::result_t want;
		if (expected_reports.size() == 0) begin
			$error("result: expected none, got outcome %0d", got.outcome);
			mismatches++;
			return;
		end
		want = expected_reports.pop_front();
		cmp_field("outcome", 64'(want.outcome), 64'(got.outcome));
		cmp_field("force_x", 64'(want.force_x), 64'(got.force_x));
		cmp_field("force_y", 64'(want.force_y), 64'(got.force_y));
		cmp_field("force_z", 64'(want.force_z), 64'(got.force_z));
		cmp_field("torque_x", 64'(want.torque_x), 64'(got.torque_x));
		cmp_field("torque_y", 64'(want.torque_y), 64'(got.torque_y));
		cmp_field("torque_z", 64'(want.torque_z), 64'(got.torque_z));
		cmp_field("device_status", 64'(want.device_status), 64'(got.device_status));
		cmp_field("good_count", 64'(want.good_count), 64'(got.good_count));
		cmp_field("lost_count", 64'(want.lost_count), 64'(got.lost_count));
		cmp_field("stale_count", 64'(want.stale_count), 64'(got.stale_count));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			tx_wait = 0;
		end else begin
			if (push && !full)
				parse_byte(item);
			// hold the request until taken
			if (!(push && full)) begin
				if (tx_wait > 0) begin
					tx_wait--;
					push <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					item <= pending_bytes.pop_front();
					push <= 1'b1;
					tx_wait = $urandom_range(0, tx_gap_max);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rx_wait = 0;
			rx_hold = 0;
		end else begin
			if (pop && !empty) begin
				check_report(result);
				rx_wait = $urandom_range(0, rx_gap_max);
			end
			if (rx_stall_req && !rx_stall_done) begin
				rx_stall_done = 1'b1;
				rx_hold = 600;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	function automatic void queue_byte(logic [7:0] b, logic eod);
		ftrr_pkg::item_t it;
		it.data_byte = b;
		it.end_of_datagram = eod;
		pending_bytes.insert(pending_bytes.size(), it);
	endfunction

	function automatic void add_bytes(int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			queue_byte(8'($urandom), i == n - 1);
	endfunction

	function automatic void add_record(logic [31:0] seq, logic [31:0] status,
			logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
			logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
		logic [31:0] w [ftrr_pkg::RecordWords];
		w = '{seq, 32'($urandom), status, fx, fy, fz, tx, ty, tz};
		for (int unsigned i = 0; i < ftrr_pkg::RecordBytes; i++)
			queue_byte(w[i >> 2][(3 - (i & 3)) * 8 +: 8], i == ftrr_pkg::RecordBytes - 1);
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			4: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic int unsigned add_datagram();
		int unsigned kind;
		int unsigned len;
		logic [31:0] step;
		logic [31:0] status;
		kind = $urandom_range(0, 19);
		if (kind < 4) begin
			len = $urandom_range(1, ftrr_pkg::RecordBytes - 1);
			add_bytes(len);
			return len;
		end
		if (kind == 4) begin
			len = $urandom_range(ftrr_pkg::RecordBytes + 1, ftrr_pkg::RecordBytes + 8);
			add_bytes(len);
			return len;
		end
		if (kind == 5) begin
			add_bytes(ftrr_pkg::RecordBytes);
			return ftrr_pkg::RecordBytes;
		end
		case ($urandom_range(0, 9))
			6: step = $urandom_range(2, 6);
			7: step = 32'h0;
			8: step = 32'h0 - $urandom_range(1, 100);
			9: step = $urandom;
			default: step = 32'h1;
		endcase
		gen_seq = gen_seq + step;
		status = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'h0;
		add_record(gen_seq, status, pick_count(), pick_count(), pick_count(),
			pick_count(), pick_count(), pick_count());
		return ftrr_pkg::RecordBytes;
	endfunction

	task automatic write_reg(logic [ftrr_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == ftrr_pkg::CfgForceScale)
			f_scale = val;
		else if (idx == ftrr_pkg::CfgTorqueScale)
			t_scale = val;
		cfg_valid <= 1'b0;
	endtask

	// advance until every byte is taken and every result is back, then let the pipe empty
	task automatic drain();
		do @(posedge clk);
		while (pending_bytes.size() != 0 || push || expected_reports.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned n_bytes;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		add_bytes(1);
		add_bytes(ftrr_pkg::RecordBytes - 1);
		add_bytes(ftrr_pkg::RecordBytes + 1);
		add_record(32'h1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0, 32'h1, 32'hFFFF_0000);
		add_record(32'h1, 32'hDEAD_BEEF, 32'h5, 32'h6, 32'h7, 32'h8, 32'h9, 32'hA);
		add_record(32'h0, 32'h0, 32'h5, 32'h6, 32'h7, 32'h8, 32'h9, 32'hA);
		add_record(32'h8000_0000, 32'h0, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
		add_record(32'hFFFF_FFFF, 32'h0, 32'h00FF_00FF, 32'hFF00_FF00, 32'h0,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		add_record(32'h4, 32'h1, 32'h3E8, 32'hFFFF_FC18, 32'h0, 32'h0, 32'h0, 32'h0);
		add_record(32'h8000_0003, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6);
		add_bytes(50);
		drain();

		write_reg(ftrr_pkg::CfgForceScale, 32'hFFFF_FFFF);
		write_reg(ftrr_pkg::CfgTorqueScale, 32'h0);
		@(negedge clk);
		add_record(32'h8000_0004, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h1, 32'h7FFF_FFFF, 32'h8000_0000);
		add_record(32'h8000_0005, 32'h0, 32'h0, 32'h1, 32'hFFFF_FFFE, 32'h1, 32'h2,
			32'h3);
		drain();

		write_reg(ftrr_pkg::CfgForceScale, 32'h0);
		write_reg(ftrr_pkg::CfgTorqueScale, 32'hFFFF_FFFF);
		write_reg(CfgSpareA, 32'h1234_5678);
		write_reg(CfgSpareB, 32'hFFFF_FFFF);
		@(negedge clk);
		add_record(32'h8000_0006, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		drain();
		gen_seq = 32'h8000_0006;

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin tx_gap_max = 14; rx_gap_max = 14; end
				1: begin tx_gap_max = 0;  rx_gap_max = 0;  end
				2: begin tx_gap_max = 3;  rx_gap_max = 14; end
				default: begin tx_gap_max = 14; rx_gap_max = 0; end
			endcase
			write_reg(ftrr_pkg::CfgForceScale, (p == 3) ? 32'hFFFF_FFFF : 32'($urandom));
			write_reg(ftrr_pkg::CfgTorqueScale, (p == 3) ? 32'h1 : 32'($urandom));
			@(negedge clk);
			if (p == 1) begin
				rx_stall_req = 1'b1;
				for (int i = 0; i < 16; i++)
					add_bytes($urandom_range(1, 4));
			end
			n_bytes = 0;
			while (n_bytes < 90)
				n_bytes += add_datagram();
			drain();
		end

		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
